[rtl/core/lkvc_pkg.sv]
`default_nettype none

package lkvc_pkg;

  // Default number of cells and fixed field widths
  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 5;

  localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // One input transaction
  typedef struct packed {
    op_e                       opcode;
    logic signed [DATA_W-1:0]  key;
    logic signed [DATA_W-1:0]  value;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic                      hit;
    logic signed [DATA_W-1:0]  read_value;
  } out_t;

  // Lookup token that walks down the cell chain
  typedef struct packed {
    logic              valid;
    logic              found;
    logic              free_found;
    logic [DATA_W-1:0] value;
  } probe_t;

  // How a cell picks itself as the target of an update
  typedef enum logic [1:0] {
    UPD_TOUCH  = 2'd0,
    UPD_EVICT  = 2'd1,
    UPD_INSERT = 2'd2
  } upd_mode_e;

  // Update broadcast from the controller to every cell
  typedef struct packed {
    logic      en;
    upd_mode_e mode;
    logic      write_value;
  } upd_t;

  typedef enum logic [1:0] {
    CTL_IDLE   = 2'd0,
    CTL_PROBE  = 2'd1,
    CTL_COMMIT = 2'd2
  } ctl_e;

endpackage

`default_nettype wire

[rtl/core/lkvc_cell.sv]
`default_nettype none

module lkvc_cell import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned IDX     = 0,
  localparam int unsigned RANK_W = $clog2(ENTRIES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [DATA_W-1:0] key_i,
  input  wire logic [DATA_W-1:0] value_i,
  input  wire upd_t              upd_i,
  input  wire logic [RANK_W-1:0] old_rank_i,
  input  wire logic [RANK_W-1:0] free_idx_i,
  input  wire probe_t            probe_i,
  input  wire logic [RANK_W-1:0] prb_rank_i,
  input  wire logic [RANK_W-1:0] prb_idx_i,
  output probe_t                 probe_o,
  output logic [RANK_W-1:0]      prb_rank_o,
  output logic [RANK_W-1:0]      prb_idx_o
);

  localparam logic [RANK_W-1:0] MY_IDX = RANK_W'(IDX);

  // Entry state
  logic              valid_q;
  logic [RANK_W-1:0] rank_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] value_q;

  // Probe stage held by this cell
  logic              pv_q;
  logic              found_q;
  logic              free_q;
  logic [DATA_W-1:0] pval_q;
  logic [RANK_W-1:0] prank_q;
  logic [RANK_W-1:0] pidx_q;

  logic match;
  logic sel;
  logic age;

  assign match = valid_q && (key_q == key_i);

  // Decide whether this cell is the update target
  always_comb begin
    case (upd_i.mode)
      UPD_TOUCH:  sel = match;
      UPD_EVICT:  sel = valid_q && (rank_q == old_rank_i);
      UPD_INSERT: sel = (free_idx_i == MY_IDX);
      default:    sel = 1'b0;
    endcase
  end

  // Entries younger than the touched one age by one; an insert ages all
  assign age = !sel && valid_q &&
               ((upd_i.mode == UPD_INSERT) || (rank_q < old_rank_i));

  // Hold valid and rank, apply the broadcast update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      pv_q    <= 1'b0;
    end else begin
      pv_q <= probe_i.valid;
      if (upd_i.en) begin
        if (sel) begin
          valid_q <= 1'b1;
          rank_q  <= '0;
        end else if (age) begin
          rank_q <= rank_q + RANK_W'(1);
        end
      end
    end
  end

  // Write key and value, advance the probe payload
  always_ff @(posedge clk_i) begin
    if (upd_i.en && sel) begin
      if (upd_i.mode != UPD_TOUCH) begin
        key_q <= key_i;
      end
      if (upd_i.write_value) begin
        value_q <= value_i;
      end
    end
    if (probe_i.valid) begin
      found_q <= probe_i.found || match;
      free_q  <= probe_i.free_found || !valid_q;
      pval_q  <= (!probe_i.found && match) ? value_q : probe_i.value;
      prank_q <= (!probe_i.found && match) ? rank_q : prb_rank_i;
      pidx_q  <= (!probe_i.free_found && !valid_q) ? MY_IDX : prb_idx_i;
    end
  end

  assign probe_o.valid      = pv_q;
  assign probe_o.found      = found_q;
  assign probe_o.free_found = free_q;
  assign probe_o.value      = pval_q;
  assign prb_rank_o         = prank_q;
  assign prb_idx_o          = pidx_q;

endmodule

`default_nettype wire

[rtl/core/lru_key_value_cache_core.sv]
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement,
// built as a chain of ENTRIES cells, each holding one key, value, valid bit
// and recency rank (0 is most recent). A get returns the stored value on a
// hit and -1 on a miss; a put returns 0 and updates, inserts into the lowest
// free cell, or evicts the least recent entry once occupancy reaches the
// capacity register (0 acts as 1, values above ENTRIES act as ENTRIES).
// One transaction is in the cache at a time: the lookup token walks the
// chain one cell per cycle, then all cells update together in one broadcast,
// which waits while the result register is full and stalled. The result
// register lets the next transaction start while the previous result still
// waits. Write the capacity only while the cache is idle. Cells come out of
// reset empty.

module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  localparam int unsigned RANK_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [CMP_W-1:0] ENTRIES_CMP = CMP_W'(ENTRIES);

  ctl_e state_q, state_d;

  logic             start_q;
  in_t              req_q;
  logic [CAP_W-1:0] cap_q;
  logic [OCC_W-1:0] occ_q;
  logic             out_valid_q;
  out_t             out_data_q;

  logic in_fire;
  logic out_free;
  logic commit_fire;
  logic occ_full;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;

  upd_t              upd;
  logic [RANK_W-1:0] old_rank;
  out_t              result;

  // Chain links
  probe_t            prb      [ENTRIES+1];
  logic [RANK_W-1:0] prb_rank [ENTRIES+1];
  logic [RANK_W-1:0] prb_idx  [ENTRIES+1];

  assign in_stall_o  = (state_q != CTL_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Inject a fresh token at the head of the chain
  assign prb[0].valid      = start_q;
  assign prb[0].found      = 1'b0;
  assign prb[0].free_found = 1'b0;
  assign prb[0].value      = '0;
  assign prb_rank[0]       = '0;
  assign prb_idx[0]        = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (req_q.key),
      .value_i    (req_q.value),
      .upd_i      (upd),
      .old_rank_i (old_rank),
      .free_idx_i (prb_idx[ENTRIES]),
      .probe_i    (prb[g]),
      .prb_rank_i (prb_rank[g]),
      .prb_idx_i  (prb_idx[g]),
      .probe_o    (prb[g+1]),
      .prb_rank_o (prb_rank[g+1]),
      .prb_idx_o  (prb_idx[g+1])
    );
  end

  // Clamp capacity to the range 1 .. ENTRIES
  assign cap_ext  = CMP_W'(cap_q);
  assign eff_cap  = (cap_ext == '0) ? CMP_W'(1) :
                    ((cap_ext > ENTRIES_CMP) ? ENTRIES_CMP : cap_ext);
  assign occ_full = CMP_W'(occ_q) >= eff_cap;

  // Sequence lookup and commit
  always_comb begin
    state_d     = state_q;
    commit_fire = 1'b0;
    case (state_q)
      CTL_IDLE: begin
        if (in_fire) state_d = CTL_PROBE;
      end
      CTL_PROBE: begin
        if (prb[ENTRIES].valid) begin
          if (out_free) begin
            commit_fire = 1'b1;
            state_d     = CTL_IDLE;
          end else begin
            state_d = CTL_COMMIT;
          end
        end
      end
      CTL_COMMIT: begin
        if (out_free) begin
          commit_fire = 1'b1;
          state_d     = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  // Form the result and the update broadcast from the finished token
  always_comb begin
    upd.en          = 1'b0;
    upd.mode        = UPD_TOUCH;
    upd.write_value = 1'b0;
    old_rank        = prb_rank[ENTRIES];
    result.hit      = prb[ENTRIES].found;
    if (req_q.opcode == OP_GET) begin
      result.read_value = prb[ENTRIES].found ? $signed(prb[ENTRIES].value) : MISS_VALUE;
      upd.en            = commit_fire && prb[ENTRIES].found;
    end else begin
      result.read_value = '0;
      upd.en            = commit_fire;
      upd.write_value   = 1'b1;
      if (!prb[ENTRIES].found) begin
        if (occ_full) begin
          upd.mode = UPD_EVICT;
          old_rank = RANK_W'(occ_q - OCC_W'(1));
        end else begin
          upd.mode = UPD_INSERT;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      start_q     <= 1'b0;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (upd.en && (upd.mode == UPD_INSERT)) begin
        occ_q <= occ_q + OCC_W'(1);
      end
      if (commit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    if (commit_fire) begin
      out_data_q <= result;
    end
  end

endmodule

`default_nettype wire

[tb/lru_key_value_cache_checker.sv]
`default_nettype none

// Watches both channels of the cache, keeps its own copy of the cache
// contents and recency order, and checks every result against it.
module lru_key_value_cache_checker import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire in_t              in_data_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire out_t             out_data_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  // Shadow copy of the cache
  logic              slot_valid [ENTRIES];
  logic [DATA_W-1:0] slot_key   [ENTRIES];
  logic [DATA_W-1:0] slot_value [ENTRIES];
  int unsigned       slot_rank  [ENTRIES];
  int unsigned       fill_level;
  logic [CAP_W-1:0]  capacity;

  // Replies predicted for accepted transactions, oldest first
  out_t predicted_replies [$];

  // Make slot s most recent; valid entries younger than old_rank age by one
  function automatic void refresh_rank(int s, int unsigned old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // Apply one get or put to the shadow cache and return its reply
  function automatic out_t access_cache(in_t txn);
    out_t        reply;
    int unsigned limit;
    int unsigned worst;
    int          slot;
    logic        found;
    logic        any;
    limit = capacity;
    if (limit < 1) limit = 1;
    if (limit > ENTRIES) limit = ENTRIES;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && slot_valid[i] && slot_key[i] == txn.key) begin
        slot  = i;
        found = 1'b1;
      end
    end
    reply.hit = found;

    if (txn.opcode == OP_GET) begin
      if (found) begin
        reply.read_value = slot_value[slot];
        refresh_rank(slot, slot_rank[slot]);
      end else begin
        reply.read_value = MISS_VALUE;
      end
      return reply;
    end

    reply.read_value = '0;
    // Update a present key in place
    if (found) begin
      slot_value[slot] = txn.value;
      refresh_rank(slot, slot_rank[slot]);
      return reply;
    end

    // Full: reuse the slot of the least recent entry
    if (fill_level >= limit) begin
      any   = 1'b0;
      worst = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && (!any || slot_rank[i] > worst)) begin
          worst = slot_rank[i];
          slot  = i;
          any   = 1'b1;
        end
      end
      if (any) begin
        slot_key[slot]   = txn.key;
        slot_value[slot] = txn.value;
        refresh_rank(slot, worst);
        return reply;
      end
    end

    // Insert into the lowest free slot
    any = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!any && !slot_valid[i]) begin
        slot = i;
        any  = 1'b1;
      end
    end
    if (any) begin
      refresh_rank(slot, 32'hFFFF_FFFF);
      slot_valid[slot] = 1'b1;
      slot_key[slot]   = txn.key;
      slot_value[slot] = txn.value;
      fill_level++;
    end
    return reply;
  endfunction

  // Check results first, then predict the transaction accepted at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_rank[i]  = 0;
      end
      fill_level = 0;
      capacity   = CAP_RESET;
      predicted_replies.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: result with none expected: hit %0b read_value %0d",
                   $time, out_data_i.hit, out_data_i.read_value);
          fail_count_o++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_data_i.hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0b actual %0b",
                     $time, want.hit, out_data_i.hit);
            fail_count_o++;
          end
          if (out_data_i.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %0d actual %0d",
                     $time, want.read_value, out_data_i.read_value);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predicted_replies.push_back(access_cache(in_data_i));
      pending_o = predicted_replies.size();
    end
  end

endmodule

`default_nettype wire

[tb/tb_lru_key_value_cache_core.sv]
`default_nettype none

module tb_lru_key_value_cache_core;
  import lkvc_pkg::*;

  localparam int unsigned ENTRIES  = ENTRIES_DEF;
  localparam int unsigned PHASES   = 9;
  localparam int unsigned POOL_MAX = 24;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = CAP_RESET;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Per phase: capacity, sender idle %, receiver stall %, key pool size, length
  int phase_cap   [PHASES] = '{16, 1, 31, 5, 16, 8, 0, 3, 12};
  int phase_idle  [PHASES] = '{0, 84, 0, 30, 30, 0, 0, 84, 30};
  int phase_stall [PHASES] = '{0, 0, 84, 30, 30, 0, 84, 0, 30};
  int phase_pool  [PHASES] = '{20, 4, 24, 8, 24, 12, 3, 6, 16};
  int phase_len   [PHASES] = '{110, 70, 110, 100, 110, 90, 40, 70, 90};

  logic [DATA_W-1:0] key_pool [POOL_MAX];

  always #6 clk_i = ~clk_i;

  lru_key_value_cache_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  lru_key_value_cache_checker #(
    .ENTRIES(ENTRIES)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Randomly stall the result channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Present one transaction after a random gap and hold it until accepted
  task automatic send_op(input op_e op, input logic [DATA_W-1:0] key,
                         input logic [DATA_W-1:0] value);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    in_data.opcode <= op;
    in_data.key    <= key;
    in_data.value  <= value;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Drain every outstanding result, then write the capacity
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [DATA_W-1:0] key;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, hit and miss, update of a present key
    send_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_op(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_op(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_op(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(OP_GET, 32'h5555_5555, 32'h0000_0000);

    // Capacity lowered below occupancy: new keys evict and reuse slots
    set_capacity(5'd2);
    send_op(OP_PUT, 32'hAAAA_AAAA, 32'h0000_0001);
    send_op(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_op(OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    send_op(OP_PUT, 32'h5555_5555, 32'h0000_0002);

    // Capacity zero acts as one
    set_capacity(5'd0);
    send_op(OP_PUT, 32'h0000_0001, 32'h0000_0003);
    send_op(OP_PUT, 32'h0000_0002, 32'h0000_0004);
    send_op(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_op(OP_GET, 32'h0000_0002, 32'h0000_0000);

    // Capacity above the entry count saturates
    set_capacity(5'd31);
    send_op(OP_PUT, 32'h0000_0003, 32'h0000_0005);
    send_op(OP_GET, 32'h0000_0000, 32'h0000_0000);

    // Random phases over a small key pool so that hits and evictions are common
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p][CAP_W-1:0]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < POOL_MAX; i++) begin
        case (i)
          0:       key_pool[i] = 32'h8000_0000;
          1:       key_pool[i] = 32'h7FFF_FFFF;
          2:       key_pool[i] = 32'hFFFF_FFFF;
          3:       key_pool[i] = 32'h0000_0000;
          default: key_pool[i] = $urandom;
        endcase
      end
      for (int n = 0; n < phase_len[p]; n++) begin
        if ($urandom_range(99) < 5) key = $urandom;
        else key = key_pool[$urandom_range(phase_pool[p] - 1)];
        send_op(op_e'($urandom_range(1)), key, pick_value());
      end
    end

    // Drain, then leave time for any stray result
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (ENTRIES + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** lru_key_value_cache_core: PASSED **");
    end else begin
      $display("** lru_key_value_cache_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4800000;
    $display("** lru_key_value_cache_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
